// ===== rtl/mieu_pkg.sv =====
// Shared types, opcodes and constants for the MIPS I integer execute unit.
package mieu_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    // major opcodes
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_REGIMM  = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BLEZ    = 6'd6;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_SLTIU   = 6'd11;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_COP0    = 6'd16;
    localparam logic [5:0] OP_COP2    = 6'd18;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LWL     = 6'd34;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_LBU     = 6'd36;
    localparam logic [5:0] OP_LHU     = 6'd37;
    localparam logic [5:0] OP_LWR     = 6'd38;
    localparam logic [5:0] OP_SB      = 6'd40;
    localparam logic [5:0] OP_SH      = 6'd41;
    localparam logic [5:0] OP_SWL     = 6'd42;
    localparam logic [5:0] OP_SW      = 6'd43;
    localparam logic [5:0] OP_SWR     = 6'd46;
    localparam logic [5:0] OP_LWC2    = 6'd50;
    localparam logic [5:0] OP_SWC2    = 6'd58;
    localparam logic [5:0] OP_HLE     = 6'd59;

    // SPECIAL functions
    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_SLLV    = 6'd4;
    localparam logic [5:0] FN_SRLV    = 6'd6;
    localparam logic [5:0] FN_SRAV    = 6'd7;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_JALR    = 6'd9;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MFHI    = 6'd16;
    localparam logic [5:0] FN_MTHI    = 6'd17;
    localparam logic [5:0] FN_MFLO    = 6'd18;
    localparam logic [5:0] FN_MTLO    = 6'd19;
    localparam logic [5:0] FN_MULT    = 6'd24;
    localparam logic [5:0] FN_MULTU   = 6'd25;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_DIVU    = 6'd27;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_ADDU    = 6'd33;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_SUBU    = 6'd35;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_NOR     = 6'd39;
    localparam logic [5:0] FN_SLT     = 6'd42;
    localparam logic [5:0] FN_SLTU    = 6'd43;

    // REGIMM selectors
    localparam logic [4:0] RI_BLTZ    = 5'd0;
    localparam logic [4:0] RI_BGEZ    = 5'd1;
    localparam logic [4:0] RI_BLTZAL  = 5'd16;
    localparam logic [4:0] RI_BGEZAL  = 5'd17;

    localparam logic [4:0] LINK_REG   = 5'd31;

    // load/store kinds
    localparam logic [3:0] MK_NONE = 4'd0;
    localparam logic [3:0] MK_LB   = 4'd1;
    localparam logic [3:0] MK_LH   = 4'd2;
    localparam logic [3:0] MK_LWL  = 4'd3;
    localparam logic [3:0] MK_LW   = 4'd4;
    localparam logic [3:0] MK_LBU  = 4'd5;
    localparam logic [3:0] MK_LHU  = 4'd6;
    localparam logic [3:0] MK_LWR  = 4'd7;
    localparam logic [3:0] MK_SB   = 4'd8;
    localparam logic [3:0] MK_SH   = 4'd9;
    localparam logic [3:0] MK_SWL  = 4'd10;
    localparam logic [3:0] MK_SW   = 4'd11;
    localparam logic [3:0] MK_SWR  = 4'd12;

    typedef enum logic [3:0] {
        HL_NONE,
        HL_MFHI,
        HL_MFLO,
        HL_MTHI,
        HL_MTLO,
        HL_MULT,
        HL_MULTU,
        HL_DIV,
        HL_DIVU
    } hl_op_t;

    typedef struct packed {
        logic [4:0]  dest_reg;
        logic        write_enable;
        logic [31:0] write_value;
        logic        branch_taken;
        logic [31:0] branch_target;
        logic [3:0]  mem_kind;
        logic [31:0] mem_address;
        logic        passed_on;
    } result_t;

    typedef struct packed {
        result_t     res;
        hl_op_t      hl_op;
        logic [31:0] rs_value;
        logic [31:0] rt_value;
    } q_entry_t;

    typedef struct packed {
        logic        start;
        logic        ack;
        logic        is_div;
        logic        is_signed;
        logic [31:0] a;
        logic [31:0] b;
    } md_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] hi;
        logic [31:0] lo;
    } md_rsp_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIX,
        MD_DONE
    } md_state_t;

    typedef enum logic {
        BK_IDLE,
        BK_BUSY
    } bk_state_t;

endpackage

// ===== rtl/mieu_front.sv =====
// Front end: decodes one instruction item into a queue entry.
module mieu_front (
    input  logic [31:0]        instr,
    input  logic [31:0]        rs_value,
    input  logic [31:0]        rt_value,
    input  logic [31:0]        next_pc,
    output mieu_pkg::q_entry_t entry
);
    import mieu_pkg::*;

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rtn;
    logic [4:0]  rdn;
    logic [4:0]  sh;
    logic [31:0] immu;
    logic [31:0] imms;
    logic [31:0] btarget;
    logic [31:0] jtarget;
    logic [31:0] link;
    logic        neg;
    result_t     r;
    hl_op_t      hl;

    assign op      = instr[31:26];
    assign fn      = instr[5:0];
    assign rtn     = instr[20:16];
    assign rdn     = instr[15:11];
    assign sh      = fn[2] ? rs_value[4:0] : instr[10:6];
    assign immu    = {16'h0000, instr[15:0]};
    assign imms    = {{16{instr[15]}}, instr[15:0]};
    assign btarget = next_pc + {imms[29:0], 2'b00};
    assign jtarget = {next_pc[31:28], instr[25:0], 2'b00};
    assign link    = next_pc + 32'd4;
    assign neg     = rs_value[31];

    always_comb
    begin
        r  = '0;
        hl = HL_NONE;
        case (op)
            OP_SPECIAL:
            begin
                case (fn)
                    FN_SLL, FN_SLLV:
                    begin
                        r.dest_reg = rdn; r.write_enable = 1'b1;
                        r.write_value = rt_value << sh;
                    end
                    FN_SRL, FN_SRLV:
                    begin
                        r.dest_reg = rdn; r.write_enable = 1'b1;
                        r.write_value = rt_value >> sh;
                    end
                    FN_SRA, FN_SRAV:
                    begin
                        r.dest_reg = rdn; r.write_enable = 1'b1;
                        r.write_value = $unsigned($signed(rt_value) >>> sh);
                    end
                    FN_JR:
                    begin
                        r.branch_taken = 1'b1; r.branch_target = rs_value;
                    end
                    FN_JALR:
                    begin
                        r.branch_taken = 1'b1; r.branch_target = rs_value;
                        r.dest_reg = rdn; r.write_enable = 1'b1; r.write_value = link;
                    end
                    FN_SYSCALL: r.passed_on = 1'b1;
                    FN_MFHI:
                    begin
                        r.dest_reg = rdn; r.write_enable = 1'b1; hl = HL_MFHI;
                    end
                    FN_MFLO:
                    begin
                        r.dest_reg = rdn; r.write_enable = 1'b1; hl = HL_MFLO;
                    end
                    FN_MTHI:  hl = HL_MTHI;
                    FN_MTLO:  hl = HL_MTLO;
                    FN_MULT:  hl = HL_MULT;
                    FN_MULTU: hl = HL_MULTU;
                    FN_DIV:   hl = HL_DIV;
                    FN_DIVU:  hl = HL_DIVU;
                    FN_ADD, FN_ADDU:
                    begin
                        r.dest_reg = rdn; r.write_enable = 1'b1;
                        r.write_value = rs_value + rt_value;
                    end
                    FN_SUB, FN_SUBU:
                    begin
                        r.dest_reg = rdn; r.write_enable = 1'b1;
                        r.write_value = rs_value - rt_value;
                    end
                    FN_AND:
                    begin
                        r.dest_reg = rdn; r.write_enable = 1'b1;
                        r.write_value = rs_value & rt_value;
                    end
                    FN_OR:
                    begin
                        r.dest_reg = rdn; r.write_enable = 1'b1;
                        r.write_value = rs_value | rt_value;
                    end
                    FN_XOR:
                    begin
                        r.dest_reg = rdn; r.write_enable = 1'b1;
                        r.write_value = rs_value ^ rt_value;
                    end
                    FN_NOR:
                    begin
                        r.dest_reg = rdn; r.write_enable = 1'b1;
                        r.write_value = ~(rs_value | rt_value);
                    end
                    FN_SLT:
                    begin
                        r.dest_reg = rdn; r.write_enable = 1'b1;
                        r.write_value = {31'd0, $signed(rs_value) < $signed(rt_value)};
                    end
                    FN_SLTU:
                    begin
                        r.dest_reg = rdn; r.write_enable = 1'b1;
                        r.write_value = {31'd0, rs_value < rt_value};
                    end
                    default: ;
                endcase
            end
            OP_REGIMM:
            begin
                case (rtn)
                    RI_BLTZ, RI_BLTZAL: r.branch_taken = neg;
                    RI_BGEZ, RI_BGEZAL: r.branch_taken = !neg;
                    default:            r.branch_taken = 1'b0;
                endcase
                if (r.branch_taken)
                begin
                    r.branch_target = btarget;
                    if (rtn[4])
                    begin
                        r.dest_reg = LINK_REG; r.write_enable = 1'b1; r.write_value = link;
                    end
                end
            end
            OP_J:
            begin
                r.branch_taken = 1'b1; r.branch_target = jtarget;
            end
            OP_JAL:
            begin
                r.branch_taken = 1'b1; r.branch_target = jtarget;
                r.dest_reg = LINK_REG; r.write_enable = 1'b1; r.write_value = link;
            end
            OP_BEQ:  r.branch_taken = (rs_value == rt_value);
            OP_BNE:  r.branch_taken = (rs_value != rt_value);
            OP_BLEZ: r.branch_taken = neg || (rs_value == 32'd0);
            OP_BGTZ: r.branch_taken = !neg && (rs_value != 32'd0);
            OP_ADDI, OP_ADDIU:
            begin
                r.dest_reg = rtn; r.write_enable = 1'b1; r.write_value = rs_value + imms;
            end
            OP_SLTI:
            begin
                r.dest_reg = rtn; r.write_enable = 1'b1;
                r.write_value = {31'd0, $signed(rs_value) < $signed(imms)};
            end
            OP_SLTIU:
            begin
                r.dest_reg = rtn; r.write_enable = 1'b1;
                r.write_value = {31'd0, rs_value < imms};
            end
            OP_ANDI:
            begin
                r.dest_reg = rtn; r.write_enable = 1'b1; r.write_value = rs_value & immu;
            end
            OP_ORI:
            begin
                r.dest_reg = rtn; r.write_enable = 1'b1; r.write_value = rs_value | immu;
            end
            OP_XORI:
            begin
                r.dest_reg = rtn; r.write_enable = 1'b1; r.write_value = rs_value ^ immu;
            end
            OP_LUI:
            begin
                r.dest_reg = rtn; r.write_enable = 1'b1;
                r.write_value = {instr[15:0], 16'h0000};
            end
            OP_COP0, OP_COP2, OP_LWC2, OP_SWC2, OP_HLE: r.passed_on = 1'b1;
            OP_LB:  r.mem_kind = MK_LB;
            OP_LH:  r.mem_kind = MK_LH;
            OP_LWL: r.mem_kind = MK_LWL;
            OP_LW:  r.mem_kind = MK_LW;
            OP_LBU: r.mem_kind = MK_LBU;
            OP_LHU: r.mem_kind = MK_LHU;
            OP_LWR: r.mem_kind = MK_LWR;
            OP_SB:  r.mem_kind = MK_SB;
            OP_SH:  r.mem_kind = MK_SH;
            OP_SWL: r.mem_kind = MK_SWL;
            OP_SW:  r.mem_kind = MK_SW;
            OP_SWR: r.mem_kind = MK_SWR;
            default: ;
        endcase

        // conditional branches share one target
        if ((op == OP_BEQ || op == OP_BNE || op == OP_BLEZ || op == OP_BGTZ)
            && r.branch_taken)
            r.branch_target = btarget;

        if (r.mem_kind != MK_NONE)
        begin
            r.mem_address = rs_value + imms;
            if (r.mem_kind <= MK_LWR)
                r.dest_reg = rtn;
        end

        // r0 is never written
        if (r.write_enable && r.dest_reg == 5'd0)
        begin
            r.write_enable = 1'b0;
            r.write_value  = '0;
        end

        entry.res      = r;
        entry.hl_op    = hl;
        entry.rs_value = rs_value;
        entry.rt_value = rt_value;
    end

endmodule

// ===== rtl/mieu_queue.sv =====
// Small FIFO of decoded items between front and back.
module mieu_queue #(
    parameter int DEPTH = mieu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mieu_pkg::q_entry_t wr_entry,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output mieu_pkg::q_entry_t rd_entry
);
    import mieu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_entry_t        mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_entry  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

// ===== rtl/mieu_muldiv.sv =====
// Iterative one-bit-per-cycle multiply and divide unit.
module mieu_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  mieu_pkg::md_req_t req,
    output mieu_pkg::md_rsp_t rsp
);
    import mieu_pkg::*;

    md_state_t   state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] b_reg, b_next;
    logic        div_reg, div_next;
    logic        neg_q_reg, neg_q_next;
    logic        neg_r_reg, neg_r_next;
    logic [32:0] msum;
    logic [32:0] rsh;
    logic [32:0] diff;
    logic [63:0] prod_neg;

    assign msum     = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, b_reg} : 33'd0);
    assign rsh      = {hi_reg, lo_reg[31]};
    assign diff     = rsh - {1'b0, b_reg};
    assign prod_neg = 64'd0 - {hi_reg, lo_reg};

    assign rsp.done = (state_reg == MD_DONE);
    assign rsp.hi   = hi_reg;
    assign rsp.lo   = lo_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        b_next     = b_reg;
        div_next   = div_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    hi_next    = '0;
                    lo_next    = (req.is_signed && req.a[31]) ? 32'd0 - req.a : req.a;
                    b_next     = (req.is_signed && req.b[31]) ? 32'd0 - req.b : req.b;
                    div_next   = req.is_div;
                    neg_q_next = req.is_signed && (req.a[31] ^ req.b[31]);
                    neg_r_next = req.is_signed && req.a[31];
                    cnt_next   = '0;
                    state_next = MD_RUN;
                end
            end
            MD_RUN:
            begin
                if (div_reg)
                begin
                    if (!diff[32])
                    begin
                        hi_next = diff[31:0];
                        lo_next = {lo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        hi_next = rsh[31:0];
                        lo_next = {lo_reg[30:0], 1'b0};
                    end
                end
                else
                begin
                    hi_next = msum[32:1];
                    lo_next = {msum[0], lo_reg[31:1]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                    state_next = MD_FIX;
            end
            MD_FIX:
            begin
                if (div_reg)
                begin
                    if (neg_q_reg)
                        lo_next = 32'd0 - lo_reg;
                    if (neg_r_reg)
                        hi_next = 32'd0 - hi_reg;
                end
                else if (neg_q_reg)
                begin
                    hi_next = prod_neg[63:32];
                    lo_next = prod_neg[31:0];
                end
                state_next = MD_DONE;
            end
            MD_DONE:
            begin
                if (req.ack)
                    state_next = MD_IDLE;
            end
            default: state_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        b_reg     <= b_next;
        div_reg   <= div_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

endmodule

// ===== rtl/mieu_back.sv =====
// Back end: HI/LO, multiply/divide sequencing and the output register.
module mieu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  mieu_pkg::q_entry_t q_entry,
    output logic               q_pop,
    output mieu_pkg::md_req_t  md_req,
    input  mieu_pkg::md_rsp_t  md_rsp,
    output logic               out_valid,
    input  logic               out_ready,
    output mieu_pkg::result_t  out_res
);
    import mieu_pkg::*;

    bk_state_t   state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg, out_res_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;
    logic        out_free;
    logic        is_md;
    logic        div_zero;

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign is_md     = (q_entry.hl_op == HL_MULT) || (q_entry.hl_op == HL_MULTU)
                    || (q_entry.hl_op == HL_DIV)  || (q_entry.hl_op == HL_DIVU);
    assign div_zero  = ((q_entry.hl_op == HL_DIV) || (q_entry.hl_op == HL_DIVU))
                    && (q_entry.rt_value == 32'd0);

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_res_next     = out_res_reg;
        hi_next          = hi_reg;
        lo_next          = lo_reg;
        q_pop            = 1'b0;
        md_req.start     = 1'b0;
        md_req.ack       = 1'b0;
        md_req.is_div    = (q_entry.hl_op == HL_DIV) || (q_entry.hl_op == HL_DIVU);
        md_req.is_signed = (q_entry.hl_op == HL_DIV) || (q_entry.hl_op == HL_MULT);
        md_req.a         = q_entry.rs_value;
        md_req.b         = q_entry.rt_value;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (is_md && !div_zero)
                    begin
                        md_req.start = 1'b1;
                        state_next   = BK_BUSY;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_res_next   = q_entry.res;
                        case (q_entry.hl_op)
                            HL_MFHI:
                                out_res_next.write_value =
                                    q_entry.res.write_enable ? hi_reg : 32'd0;
                            HL_MFLO:
                                out_res_next.write_value =
                                    q_entry.res.write_enable ? lo_reg : 32'd0;
                            HL_MTHI: hi_next = q_entry.rs_value;
                            HL_MTLO: lo_next = q_entry.rs_value;
                            default: ;
                        endcase
                    end
                end
            end
            BK_BUSY:
            begin
                if (md_rsp.done && out_free)
                begin
                    md_req.ack     = 1'b1;
                    hi_next        = md_rsp.hi;
                    lo_next        = md_rsp.lo;
                    out_valid_next = 1'b1;
                    out_res_next   = '0;
                    state_next     = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            hi_reg        <= '0;
            lo_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

endmodule

// ===== rtl/mips1_integer_execute_unit.sv =====
// Top level of the MIPS I integer execute unit: front, queue, back and mul/div unit.
//
// One instruction item in, one result item out, in order. The front decodes
// each item as it arrives and writes it into a small queue (QUEUE_DEPTH
// entries); in_ready is high while the queue has room. The back takes one item
// from the queue per cycle, while it is idle and the output stage is free, into
// a registered output stage, so plain ALU, shift, branch, jump, load/store and
// HI/LO move results are registered there once they reach the head of the queue.
// MULT, MULTU, DIV and DIVU go through a shared iterative unit that handles one
// bit per cycle: 32 steps plus a sign-fix step, and later items wait in the
// queue behind such an item while it occupies the back. A divide by zero skips
// the unit and leaves HI/LO untouched. The result of a multiply or divide is an
// all-zero item. HI and LO reset to zero.
module mips1_integer_execute_unit #(
    parameter int QUEUE_DEPTH = mieu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] instr,
    input  logic [31:0] rs_value,
    input  logic [31:0] rt_value,
    input  logic [31:0] next_pc,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  dest_reg,
    output logic        write_enable,
    output logic [31:0] write_value,
    output logic        branch_taken,
    output logic [31:0] branch_target,
    output logic [3:0]  mem_kind,
    output logic [31:0] mem_address,
    output logic        passed_on
);
    import mieu_pkg::*;

    q_entry_t fe_entry;
    q_entry_t q_entry;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    md_req_t  md_req;
    md_rsp_t  md_rsp;
    result_t  res;

    assign in_ready = !q_full;

    mieu_front u_front (
        .instr    (instr),
        .rs_value (rs_value),
        .rt_value (rt_value),
        .next_pc  (next_pc),
        .entry    (fe_entry)
    );

    mieu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .wr_entry  (fe_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .rd_entry  (q_entry)
    );

    mieu_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    mieu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .md_req    (md_req),
        .md_rsp    (md_rsp),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    assign dest_reg      = res.dest_reg;
    assign write_enable  = res.write_enable;
    assign write_value   = res.write_value;
    assign branch_taken  = res.branch_taken;
    assign branch_target = res.branch_target;
    assign mem_kind      = res.mem_kind;
    assign mem_address   = res.mem_address;
    assign passed_on     = res.passed_on;

    // the back never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // the unit is idle whenever a new operation is started
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        md_req.start |-> !md_rsp.done)
        else $error("mul/div started while holding a result");

    // a finished product or quotient is held until the back takes it
    a_done_held: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done && !md_req.ack |=> md_rsp.done)
        else $error("mul/div result dropped before acknowledge");

endmodule
